>>> rtl/i2cst_pkg.sv
// Types, constants and helper functions shared by the I2C trace core.
`default_nettype none
package i2cst_pkg;

   localparam logic [7:0] CHAR_START   = 8'h2A;   // '*'
   localparam logic [7:0] CHAR_RESTART = 8'h23;   // '#'
   localparam logic [7:0] CHAR_STOP    = 8'h2E;   // '.'
   localparam logic [7:0] CHAR_ACK     = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_NACK    = 8'h2D;   // '-'
   localparam logic [15:0] LIMIT_RESET = 16'd4000;
   localparam logic [3:0] BITS_PER_BYTE = 4'd9;
   localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

   typedef enum logic [2:0] {
      PH_WAIT_IDLE  = 3'd0,
      PH_WAIT_START = 3'd1,
      PH_WAIT_LOW   = 3'd2,
      PH_CLOCK_LOW  = 3'd3,
      PH_HIGH_SDA1  = 3'd4,
      PH_HIGH_SDA0  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_FINISH = 2'd0,
      EV_MARK   = 2'd1,
      EV_BYTE   = 2'd2
   } ev_kind_type;

   // One classified bus event, expanded into one to four records downstream.
   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  mark_char;
      logic [7:0]  byte_val;
      logic        nack;
      logic [15:0] base_count;
      logic        finish;
   } ev_type;

   function automatic logic [15:0] sat_add(input logic [15:0] count, input logic [1:0] inc);
      logic [16:0] sum;
      sum = {1'b0, count} + {15'd0, inc};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

endpackage
`default_nettype wire

>>> rtl/i2cst_if.sv
// Valid/ready channel interfaces for samples, trace records and the limit register.
`default_nettype none
interface i2cst_req_if;
   logic valid;
   logic ready;
   logic data_line;
   logic clock_line;
   logic abort_request;
   modport source (output valid, data_line, clock_line, abort_request, input ready);
   modport sink (input valid, data_line, clock_line, abort_request, output ready);
endinterface

interface i2cst_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [7:0]  trace_char;
   logic [15:0] chars_total;
   logic        last_of_run;
   modport source (output valid, record_kind, trace_char, chars_total, last_of_run,
                   input ready);
   modport sink (input valid, record_kind, trace_char, chars_total, last_of_run,
                 output ready);
endinterface

interface i2cst_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] capture_limit;
   modport source (output valid, capture_limit, input ready);
   modport sink (input valid, capture_limit, output ready);
endinterface
`default_nettype wire

>>> rtl/i2cst_front.sv
// Bus phase tracker: follows START/STOP and bit timing and issues bus events.
`default_nettype none
module i2cst_front #(
   parameter int BYTE_MARGIN = 10
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  smp_valid,
   output logic                 smp_ready,
   input  wire                  data_line,
   input  wire                  clock_line,
   input  wire                  abort_request,
   input  wire                  csr_valid,
   input  wire  [15:0]          csr_data,
   input  wire                  ev_full,
   output logic                 ev_push,
   output i2cst_pkg::ev_type    ev_data
);
   import i2cst_pkg::*;

   localparam logic [15:0] MARGIN = 16'(BYTE_MARGIN);

   phase_type   phase_ff, phase_in;
   logic [8:0]  shift_ff, shift_in;
   logic [3:0]  bcnt_ff, bcnt_in;
   logic [15:0] count_ff, count_in;
   logic        finished_ff, finished_in;
   logic [15:0] limit_ff;
   logic [15:0] byte_thr;
   logic [15:0] cnt_plus1, cnt_plus3;
   logic        accept;

   assign smp_ready = finished_ff || !ev_full;
   assign accept    = smp_valid && smp_ready && !finished_ff;
   assign byte_thr  = (limit_ff > MARGIN) ? (limit_ff - MARGIN) : 16'd0;
   assign cnt_plus1 = sat_add(count_ff, 2'd1);
   assign cnt_plus3 = sat_add(count_ff, 2'd3);

   always_comb begin
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      bcnt_in     = bcnt_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      ev_push     = 1'b0;
      ev_data.kind       = EV_FINISH;
      ev_data.mark_char  = 8'd0;
      ev_data.byte_val   = 8'd0;
      ev_data.nack       = 1'b0;
      ev_data.base_count = count_ff;
      ev_data.finish     = 1'b1;
      if (accept) begin
         if (abort_request) begin
            ev_push     = 1'b1;
            finished_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_WAIT_IDLE: begin
                  if (data_line && clock_line) phase_in = PH_WAIT_START;
               end
               PH_WAIT_START: begin
                  if (!data_line && clock_line) begin
                     ev_push           = 1'b1;
                     ev_data.kind      = EV_MARK;
                     ev_data.mark_char = CHAR_START;
                     ev_data.finish    = cnt_plus1 >= limit_ff;
                     count_in          = cnt_plus1;
                     finished_in       = ev_data.finish;
                     shift_in          = 9'd0;
                     bcnt_in           = 4'd0;
                     phase_in          = PH_WAIT_LOW;
                  end
               end
               PH_WAIT_LOW: begin
                  if (!clock_line) phase_in = PH_CLOCK_LOW;
               end
               PH_CLOCK_LOW: begin
                  if (clock_line) phase_in = data_line ? PH_HIGH_SDA1 : PH_HIGH_SDA0;
               end
               PH_HIGH_SDA1, PH_HIGH_SDA0: begin
                  if (!clock_line) begin
                     // Falling SCL: the bit level is the one seen when SCL rose.
                     shift_in = {shift_ff[7:0], (phase_ff == PH_HIGH_SDA1)};
                     bcnt_in  = bcnt_ff + 4'd1;
                     phase_in = PH_CLOCK_LOW;
                     if (bcnt_in >= BITS_PER_BYTE) begin
                        ev_push          = 1'b1;
                        ev_data.kind     = EV_BYTE;
                        ev_data.byte_val = shift_in[8:1];
                        ev_data.nack     = shift_in[0];
                        ev_data.finish   = cnt_plus3 >= byte_thr;
                        count_in         = cnt_plus3;
                        finished_in      = ev_data.finish;
                        shift_in         = 9'd0;
                        bcnt_in          = 4'd0;
                     end
                  end else if (data_line != (phase_ff == PH_HIGH_SDA1)) begin
                     // SDA moved while SCL high: repeated START or STOP.
                     ev_push           = 1'b1;
                     ev_data.kind      = EV_MARK;
                     ev_data.mark_char = (phase_ff == PH_HIGH_SDA1) ? CHAR_RESTART
                                                                   : CHAR_STOP;
                     ev_data.finish    = cnt_plus1 >= limit_ff;
                     count_in          = cnt_plus1;
                     finished_in       = ev_data.finish;
                     shift_in          = 9'd0;
                     bcnt_in           = 4'd0;
                     phase_in          = (phase_ff == PH_HIGH_SDA1) ? PH_WAIT_LOW
                                                                   : PH_WAIT_START;
                  end
               end
               default: phase_in = PH_WAIT_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_IDLE;
         shift_ff    <= 9'd0;
         bcnt_ff     <= 4'd0;
         count_ff    <= 16'd0;
         finished_ff <= 1'b0;
         limit_ff    <= LIMIT_RESET;
      end else begin
         phase_ff    <= phase_in;
         shift_ff    <= shift_in;
         bcnt_ff     <= bcnt_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         if (csr_valid) limit_ff <= csr_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/i2cst_queue.sv
// Small event queue between the phase tracker and the record emitter.
`default_nettype none
module i2cst_queue #(
   parameter int DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire i2cst_pkg::ev_type push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output i2cst_pkg::ev_type    head
);
   import i2cst_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   ev_type        slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full      = fill_ff == FULL_COUNT;
   assign not_empty = fill_ff != '0;
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1);
      if (do_pop)  rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) fill_in = fill_ff + CW'(1);
      else if (do_pop && !do_push) fill_in = fill_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

>>> rtl/i2cst_back.sv
// Record emitter: each event gives its trace records, one per cycle when ready.
`default_nettype none
module i2cst_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  ev_avail,
   input  wire i2cst_pkg::ev_type ev_head,
   output logic                 ev_pop,
   output logic                 rec_valid,
   input  wire                  rec_ready,
   output logic                 record_kind,
   output logic [7:0]           trace_char,
   output logic [15:0]          chars_total,
   output logic                 last_of_run
);
   import i2cst_pkg::*;

   ev_type     cur_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] nchars, last_idx, step;
   logic       at_last, is_char;

   always_comb begin
      case (cur_ff.kind)
         EV_MARK: nchars = 2'd1;
         EV_BYTE: nchars = 2'd3;
         default: nchars = 2'd0;
      endcase
   end

   assign last_idx = 2'(nchars + {1'b0, cur_ff.finish} - 2'd1);
   assign at_last  = idx_ff == last_idx;
   assign is_char  = idx_ff < nchars;
   assign step     = is_char ? 2'(idx_ff + 2'd1) : nchars;

   always_comb begin
      record_kind = !is_char;
      chars_total = sat_add(cur_ff.base_count, step);
      last_of_run = at_last;
      trace_char  = 8'd0;
      if (is_char) begin
         case (cur_ff.kind)
            EV_MARK: trace_char = cur_ff.mark_char;
            EV_BYTE: begin
               case (idx_ff)
                  2'd0:    trace_char = hex_char(4'((cur_ff.byte_val & HI_NIBBLE_MASK) >> 4));
                  2'd1:    trace_char = hex_char(4'(cur_ff.byte_val & LO_NIBBLE_MASK));
                  default: trace_char = cur_ff.nack ? CHAR_NACK : CHAR_ACK;
               endcase
            end
            default: trace_char = 8'd0;
         endcase
      end
   end

   assign rec_valid = busy_ff;
   // Load the next event when empty or when the last record transfers now.
   assign ev_pop    = ev_avail && (!busy_ff || (rec_ready && at_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (ev_pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (busy_ff && rec_ready) begin
         if (at_last) busy_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) cur_ff <= ev_head;
   end

endmodule
`default_nettype wire

>>> rtl/i2cst_core.sv
// Limit register port adapter that acknowledges every write at once.
`default_nettype none
module i2cst_core (
   i2cst_csr_if.sink  csr_chan,
   output logic       wr_en,
   output logic [15:0] wr_data
);
   assign csr_chan.ready = 1'b1;
   assign wr_en   = csr_chan.valid & csr_chan.ready;
   assign wr_data = csr_chan.capture_limit;
endmodule
`default_nettype wire

>>> rtl/i2c_bus_sniffer_ascii_trace_core.sv
// Top level of the I2C bus sniffer that emits an ASCII trace.
// One SDA/SCL/abort sample is taken per cycle. The phase tracker classifies each
// sample and posts START, repeated START, STOP, byte and finish events into a
// QUEUE_DEPTH-entry queue; the emitter turns each event into its records at one
// record per cycle while the result side is ready: a mark gives 1 or 2 records,
// a byte 3 or 4, an abort 1. Sample input ready drops only while the queue is
// full, so a stalled result side holds back samples once the emitter holds one
// event and the queue QUEUE_DEPTH more. Once capture has finished, samples are
// still taken every cycle and discarded. Limit writes are acknowledged at once.
`default_nettype none
module i2c_bus_sniffer_ascii_trace_core #(
   parameter int BYTE_MARGIN = 10,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   i2cst_req_if.sink  req_chan,
   i2cst_rsp_if.source rsp_chan,
   i2cst_csr_if.sink  csr_chan
);
   import i2cst_pkg::*;

   ev_type      push_data, head;
   logic        push, full, pop, not_empty;
   logic        lim_wr;
   logic [15:0] lim_data;

   i2cst_core u_csr (
      .csr_chan (csr_chan),
      .wr_en    (lim_wr),
      .wr_data  (lim_data)
   );

   i2cst_front #(.BYTE_MARGIN(BYTE_MARGIN)) u_front (
      .clock         (clock),
      .reset         (reset),
      .smp_valid     (req_chan.valid),
      .smp_ready     (req_chan.ready),
      .data_line     (req_chan.data_line),
      .clock_line    (req_chan.clock_line),
      .abort_request (req_chan.abort_request),
      .csr_valid     (lim_wr),
      .csr_data      (lim_data),
      .ev_full       (full),
      .ev_push       (push),
      .ev_data       (push_data)
   );

   i2cst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   i2cst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .ev_avail    (not_empty),
      .ev_head     (head),
      .ev_pop      (pop),
      .rec_valid   (rsp_chan.valid),
      .rec_ready   (rsp_chan.ready),
      .record_kind (rsp_chan.record_kind),
      .trace_char  (rsp_chan.trace_char),
      .chars_total (rsp_chan.chars_total),
      .last_of_run (rsp_chan.last_of_run)
   );

endmodule
`default_nettype wire

>>> tb/sv/i2cst_trace_check.sv
// Checker for the I2C trace core: predicts the trace records and compares every result transfer.
module i2cst_trace_check #(
   parameter int BYTE_MARGIN = 10
) (
   input  logic        clock,
   input  logic        reset,
   i2cst_req_if        req_mon,
   i2cst_rsp_if        rsp_mon,
   i2cst_csr_if        csr_mon,
   output int          fail_count,
   output int          records_owed,
   output logic [15:0] chars_so_far,
   output logic        capture_done
);
   import i2cst_pkg::*;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch;
      logic [15:0] total;
      logic        last;
   } trace_rec_type;

   phase_type     line_phase;
   logic [8:0]    shift_reg;
   logic [3:0]    bits_in;
   logic [15:0]   emitted;
   logic          stopped;
   logic [15:0]   limit_reg;
   trace_rec_type trace_owed[$];
   trace_rec_type burst[$];

   function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h41 + {4'd0, nib} - 8'd10;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("trace check: %s", msg);
      fail_count = fail_count + 1;
   endtask

   task automatic add_char(input logic [7:0] ch);
      trace_rec_type r;
      if (emitted != 16'hFFFF) begin
         emitted = emitted + 16'd1;
      end
      r = '{kind: KIND_CHAR, ch: ch, total: emitted, last: 1'b0};
      burst.push_back(r);
   endtask

   task automatic add_finish();
      trace_rec_type r;
      r = '{kind: KIND_DONE, ch: 8'h00, total: emitted, last: 1'b0};
      burst.push_back(r);
      stopped = 1'b1;
   endtask

   task automatic shift_bit(input logic b);
      logic [7:0]  data;
      logic [15:0] thr;
      shift_reg = {shift_reg[7:0], b};
      bits_in = bits_in + 4'd1;
      line_phase = PH_CLOCK_LOW;
      if (bits_in >= BITS_PER_BYTE) begin
         data = shift_reg[8:1];
         add_char(nibble_ascii(data[7:4]));
         add_char(nibble_ascii(data[3:0]));
         add_char(shift_reg[0] ? CHAR_NACK : CHAR_ACK);
         shift_reg = '0;
         bits_in = '0;
         // Byte records stop short of the limit; a small limit leaves no room at all.
         thr = (limit_reg > 16'(BYTE_MARGIN)) ? limit_reg - 16'(BYTE_MARGIN) : 16'd0;
         if (emitted >= thr) begin
            add_finish();
         end
      end
   endtask

   task automatic mark(input logic [7:0] ch, input phase_type nxt);
      add_char(ch);
      shift_reg = '0;
      bits_in = '0;
      line_phase = nxt;
      if (emitted >= limit_reg) begin
         add_finish();
      end
   endtask

   task automatic predict_sample(input logic sda, input logic scl, input logic abrt);
      trace_rec_type r;
      burst.delete();
      if (stopped) begin
         return;
      end
      if (abrt) begin
         add_finish();
      end else begin
         case (line_phase)
            PH_WAIT_IDLE: begin
               if (sda && scl) line_phase = PH_WAIT_START;
            end
            PH_WAIT_START: begin
               if (!sda && scl) mark(CHAR_START, PH_WAIT_LOW);
            end
            PH_WAIT_LOW: begin
               if (!scl) line_phase = PH_CLOCK_LOW;
            end
            PH_CLOCK_LOW: begin
               if (scl) line_phase = sda ? PH_HIGH_SDA1 : PH_HIGH_SDA0;
            end
            PH_HIGH_SDA1: begin
               if (!scl) shift_bit(1'b1);
               else if (!sda) mark(CHAR_RESTART, PH_WAIT_LOW);
            end
            PH_HIGH_SDA0: begin
               if (!scl) shift_bit(1'b0);
               else if (sda) mark(CHAR_STOP, PH_WAIT_START);
            end
            default: begin
               line_phase = PH_WAIT_IDLE;
            end
         endcase
      end
      if (burst.size() > 0) begin
         r = burst.pop_back();
         r.last = 1'b1;
         burst.push_back(r);
      end
      foreach (burst[i]) trace_owed.push_back(burst[i]);
   endtask

   always @(posedge clock) begin
      trace_rec_type want;
      if (reset) begin
         line_phase = PH_WAIT_IDLE;
         shift_reg = '0;
         bits_in = '0;
         emitted = '0;
         stopped = 1'b0;
         limit_reg = LIMIT_RESET;
         trace_owed.delete();
         fail_count = 0;
      end else begin
         // Results are checked before the sample of this edge is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (trace_owed.size() == 0) begin
               report_mismatch($sformatf("unexpected record kind %0d char %02h count %0d",
                  rsp_mon.record_kind, rsp_mon.trace_char, rsp_mon.chars_total));
            end else begin
               want = trace_owed.pop_front();
               if (rsp_mon.record_kind !== want.kind)
                  report_mismatch($sformatf("record_kind %0d, expected %0d",
                     rsp_mon.record_kind, want.kind));
               if (rsp_mon.trace_char !== want.ch)
                  report_mismatch($sformatf("trace_char %02h, expected %02h",
                     rsp_mon.trace_char, want.ch));
               if (rsp_mon.chars_total !== want.total)
                  report_mismatch($sformatf("chars_total %0d, expected %0d",
                     rsp_mon.chars_total, want.total));
               if (rsp_mon.last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0d, expected %0d",
                     rsp_mon.last_of_run, want.last));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            limit_reg = csr_mon.capture_limit;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_sample(req_mon.data_line, req_mon.clock_line, req_mon.abort_request);
         end
      end
      records_owed = trace_owed.size();
      chars_so_far = emitted;
      capture_done = stopped;
   end

endmodule

>>> tb/sv/tb.sv
// Top of the I2C trace core testbench: bus stimulus, limit writes, result stalls and verdict.
module tb;
   import i2cst_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_PAUSE = 24;
   localparam logic [15:0] LIMIT_MAX = 16'hFFFF;
   localparam logic [15:0] LIMIT_MIN = 16'd16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cst_req_if req_bus ();
   i2cst_rsp_if rsp_bus ();
   i2cst_csr_if csr_bus ();

   int          fail_count;
   int          records_owed;
   logic [15:0] chars_so_far;
   logic        capture_done;
   int          sent;
   int          idle_cycles = 0;
   logic        cur_sda;
   bit          quick;
   bit          steady;

   i2c_bus_sniffer_ascii_trace_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   i2cst_trace_check trace_mon (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (fail_count),
      .records_owed (records_owed),
      .chars_so_far (chars_so_far),
      .capture_done (capture_done)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: free-running stretches, short stalls and the odd long one.
   initial begin
      int choice;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         choice = $urandom_range(0, 9);
         if (choice < 3) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(5, 30)) @(negedge clock);
         end else if (choice < 9) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (steady || r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_hold();
      int r;
      r = $urandom_range(0, 9);
      if (quick || r < 7) return 1;
      if (r < 9) return 2;
      return $urandom_range(3, 6);
   endfunction

   task automatic push_sample(input logic sda, input logic scl, input logic abrt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_line <= sda;
      req_bus.clock_line <= scl;
      req_bus.abort_request <= abrt;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic drive_lines(input logic sda, input logic scl);
      repeat (pick_hold()) push_sample(sda, scl, 1'b0);
      cur_sda = sda;
   endtask

   // Lowers valid and waits until every predicted record has been seen.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (records_owed != 0);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      settle();
      csr_bus.valid <= 1'b1;
      csr_bus.capture_limit <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_start();
      drive_lines(1'b1, 1'b1);
      drive_lines(1'b0, 1'b1);
   endtask

   // The falling SCL edge at the head of each bit clocks in the previous one.
   task automatic send_bit(input logic b);
      drive_lines(cur_sda, 1'b0);
      if (b != cur_sda) drive_lines(b, 1'b0);
      drive_lines(b, 1'b1);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic nack);
      for (int i = 7; i >= 0; i--) send_bit(data[i]);
      send_bit(nack);
   endtask

   task automatic send_restart();
      drive_lines(cur_sda, 1'b0);
      drive_lines(1'b1, 1'b0);
      drive_lines(1'b1, 1'b1);
      drive_lines(1'b0, 1'b1);
   endtask

   task automatic send_stop();
      drive_lines(cur_sda, 1'b0);
      drive_lines(1'b0, 1'b0);
      drive_lines(1'b0, 1'b1);
      drive_lines(1'b1, 1'b1);
   endtask

   task automatic send_noise(input int count, input bit with_abort);
      logic sda;
      logic scl;
      repeat (count) begin
         sda = 1'($urandom_range(0, 1));
         scl = 1'($urandom_range(0, 1));
         push_sample(sda, scl, with_abort ? 1'($urandom_range(0, 1)) : 1'b0);
         cur_sda = sda;
      end
   endtask

   task automatic send_transfer();
      logic [7:0] data;
      int         choice;
      send_start();
      repeat ($urandom_range(1, 3)) begin
         choice = $urandom_range(0, 7);
         data = (choice == 0) ? 8'h00 : (choice == 1) ? 8'hFF : 8'($urandom);
         send_byte(data, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) send_restart();
      end
      send_stop();
   endtask

   // A START followed by a partial byte cut off by STOP or repeated START.
   task automatic send_broken();
      send_start();
      repeat ($urandom_range(1, 8)) send_bit(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) send_stop();
      else send_restart();
      if ($urandom_range(0, 1) == 0) send_noise($urandom_range(1, 4), 1'b0);
   endtask

   task automatic run_random(input int quota);
      int target;
      int choice;
      target = sent + quota;
      while (sent < target) begin
         steady = ($urandom_range(0, 3) == 0);
         choice = $urandom_range(0, 9);
         if (choice == 0) send_noise($urandom_range(2, 8), 1'b0);
         else if (choice == 1) send_broken();
         else send_transfer();
         if ($urandom_range(0, 9) == 0) begin
            req_bus.valid <= 1'b0;
            do @(negedge clock); while (records_owed != 0);
         end
      end
   endtask

   initial begin
      int ending;
      int tries;
      cur_sda = 1'b1;
      quick = 1'b1;
      steady = 1'b1;
      sent = 0;
      req_bus.valid = 1'b0;
      req_bus.data_line = 1'b1;
      req_bus.clock_line = 1'b1;
      req_bus.abort_request = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.capture_limit = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The short directed trace stays below even the smallest limit.
      write_limit(LIMIT_MIN);
      send_start();
      send_byte(8'hFF, 1'b1);
      send_restart();
      send_stop();

      quick = 1'b0;
      write_limit(LIMIT_MAX);
      run_random(10);
      write_limit(16'($urandom_range(1000, 65534)));
      run_random(5);
      write_limit(LIMIT_RESET);
      run_random(5);

      // Capture ends by abort, by a limit far below the count, or by one just above it.
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
         write_limit(LIMIT_MIN);
         push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
         if (ending == 1) write_limit(LIMIT_MIN);
         else write_limit(chars_so_far + 16'($urandom_range(1, 12)));
         tries = 0;
         while (!capture_done && tries < 40) begin
            send_transfer();
            tries++;
         end
      end
      // Everything after the finish record is dropped without a result.
      push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      send_noise(6, 1'b1);

      req_bus.valid <= 1'b0;
      do @(negedge clock); while (records_owed != 0);
      repeat (DRAIN_PAUSE) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
